// ----- rtl/epvt_pkg.sv -----
// Shared types, constants and helper functions for the encoder position and velocity tracker.
`timescale 1ns / 1ps
`default_nettype none

package epvt_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int DIV_W   = 68;
    localparam int DEN_W   = 48;
    localparam int QUO_W   = 33;
    localparam int ITER_W  = 7;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [ITER_W-1:0] ITERS_32  = ITER_W'(32);
    localparam logic [ITER_W-1:0] ITERS_VEL = ITER_W'(DIV_W);
    localparam logic [ITER_W-1:0] ITERS_ACC = ITER_W'(PROD_W);

    localparam logic [15:0]        EPR_RESET    = 16'd4096;
    localparam logic [MUL_B_W-1:0] CDEG_PER_REV = MUL_B_W'(36000);
    localparam logic [MUL_B_W-1:0] US_PER_S     = MUL_B_W'(1000000);
    localparam logic [15:0]        CDEG_REV16   = 16'd36000;
    localparam logic [15:0]        CDEG_HALF    = 16'd18000;

    localparam logic [1:0] LIMIT_NONE = 2'd0;
    localparam logic [1:0] LIMIT_HIGH = 2'd1;
    localparam logic [1:0] LIMIT_LOW  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OFS,
        ST_POS,
        ST_CMP,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_ANG_MUL,
        ST_ANG_GO,
        ST_ANG_WAIT,
        ST_DEN_MUL,
        ST_NUM_MUL,
        ST_LO_MUL,
        ST_HI_MUL,
        ST_SUM,
        ST_VEL_GO,
        ST_VEL_WAIT,
        ST_DV_MUL,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quot;
        logic [DEN_W-1:0] rem;
    } div_rsp_t;

    function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Applies the sign to a rate magnitude, saturating to -2^31 for negative and 2^31-1 for positive results.
    function automatic logic signed [31:0] rate_sat(input logic neg, input logic ovf,
                                                    input logic [QUO_W-1:0] q);
        logic        big;
        logic [31:0] mag;
        logic [31:0] r;
        big = ovf | q[QUO_W-1] | q[31];
        mag = big ? 32'h8000_0000 : q[31:0];
        if (neg) begin
            r = 32'd0 - mag;
        end else begin
            r = big ? 32'h7FFF_FFFF : mag;
        end
        return $signed(r);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/epvt_ifs.sv -----
// Valid/ready channel interfaces for the tracker's input items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface epvt_in_if #(parameter int COUNT_BITS = epvt_pkg::COUNT_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COUNT_BITS-1:0] raw_count;
    logic [1:0]                   limit_event;
    logic [31:0]                  time_us;

    modport source(output valid, raw_count, limit_event, time_us, input ready);
    modport sink(input valid, raw_count, limit_event, time_us, output ready);
endinterface

interface epvt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [15:0] angle_centideg;
    logic signed [31:0] velocity_centideg_s;
    logic signed [31:0] accel_centideg_s2;

    modport source(output valid, position, angle_centideg, velocity_centideg_s,
                   accel_centideg_s2, input ready);
    modport sink(input valid, position, angle_centideg, velocity_centideg_s,
                 accel_centideg_s2, output ready);
endinterface

`default_nettype wire

// ----- rtl/encoder_position_velocity_tracker_unit.sv -----
// Top level of the encoder position, angle, velocity and acceleration tracker.
//
// The sample channel takes one poll of the edge counter per item: raw count, limit event
// and microsecond timestamp. The result channel returns position, wrapped angle, velocity
// and acceleration, but only for items whose position differs from the previous one.
// The edges-per-revolution register is written through cfg_wr_en and cfg_wr_data.
// One item is worked on at a time by a sequencer driving one shared multiplier and one
// shared radix-2 divider. An item that leaves the position unchanged returns to idle from
// the compare state. An item with zero elapsed time ends after the modulo and angle passes;
// a full update adds the velocity and acceleration passes of the divider.
// The result is loaded into the output register from ST_OUT after the last divider pass.
// Reset clears the position offset, the last position, time, velocity and acceleration,
// and loads 4096 into the edges-per-revolution register. A stalled receiver holds the
// result in the output register; the next item is still accepted and worked on, and its
// result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module encoder_position_velocity_tracker_unit #(
    parameter int COUNT_BITS = epvt_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    epvt_in_if.sink          sample,
    epvt_out_if.source       result
);

    localparam logic signed [33:0] LIM_HI = (34'sd1 <<< (COUNT_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] LIM_LO = -(34'sd1 <<< (COUNT_BITS - 1));

    epvt_pkg::state_t state_reg;
    epvt_pkg::state_t state_next;

    epvt_pkg::mul_req_t              mul_req;
    logic [epvt_pkg::PROD_W-1:0]     mul_prod;
    epvt_pkg::div_req_t              div_req;
    epvt_pkg::div_rsp_t              div_rsp;

    logic [15:0]        epr_reg;
    logic signed [31:0] offset_reg;
    logic signed [31:0] last_pos_reg;
    logic [31:0]        last_time_reg;
    logic signed [31:0] last_vel_reg;
    logic signed [31:0] held_acc_reg;

    logic signed [COUNT_BITS-1:0] raw_reg;
    logic [1:0]                   ev_reg;
    logic [31:0]                  time_reg;
    logic signed [31:0]           pos_reg;
    logic                         dneg_reg;
    logic [31:0]                  dmag_reg;
    logic                         pneg_reg;
    logic [31:0]                  pmag_reg;
    logic [31:0]                  dt_reg;
    logic [15:0]                  modr_reg;
    logic signed [15:0]           ang_reg;
    logic [47:0]                  den_reg;
    logic [47:0]                  x_reg;
    logic [44:0]                  lo_reg;
    logic [epvt_pkg::DIV_W-1:0]   num_reg;
    logic signed [31:0]           vel_reg;
    logic signed [31:0]           acc_reg;
    logic                         dvneg_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg;
    logic signed [15:0] out_ang_reg;
    logic signed [31:0] out_vel_reg;
    logic signed [31:0] out_acc_reg;

    logic [15:0]                epr_eff;
    logic signed [33:0]         ofs_ext;
    logic signed [33:0]         raw_ext;
    logic signed [32:0]         delta;
    logic [32:0]                delta_abs;
    logic [32:0]                pos_abs;
    logic [15:0]                mod_raw;
    logic [15:0]                mod_fix;
    logic [15:0]                ang_q;
    logic [15:0]                ang_val;
    logic signed [32:0]         dv;
    logic [32:0]                dv_abs;
    logic [epvt_pkg::DIV_W-1:0] num_sum;
    logic signed [31:0]         vel_val;
    logic signed [31:0]         acc_val;
    logic                       out_load;

    epvt_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    epvt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign epr_eff   = (epr_reg == 16'd0) ? 16'd1 : epr_reg;
    assign ofs_ext   = 34'(offset_reg);
    assign raw_ext   = 34'(raw_reg);
    assign delta     = 33'(pos_reg) - 33'(last_pos_reg);
    assign delta_abs = delta[32] ? 33'd0 - delta : delta;
    assign pos_abs   = pos_reg[31] ? 33'd0 - 33'(pos_reg) : 33'(pos_reg);
    assign mod_raw   = div_rsp.rem[15:0];
    assign mod_fix   = (pneg_reg && mod_raw != 16'd0) ? epr_eff - mod_raw : mod_raw;
    assign ang_q     = div_rsp.quot[15:0];
    assign ang_val   = (ang_q >= epvt_pkg::CDEG_HALF) ? ang_q - epvt_pkg::CDEG_REV16 : ang_q;
    assign dv        = 33'(vel_reg) - 33'(last_vel_reg);
    assign dv_abs    = dv[32] ? 33'd0 - dv : dv;
    assign num_sum   = {mul_prod[42:0], 25'd0} + epvt_pkg::DIV_W'(lo_reg);
    assign vel_val   = epvt_pkg::rate_sat(dneg_reg, div_rsp.ovf, div_rsp.quot);
    assign acc_val   = epvt_pkg::rate_sat(dvneg_reg, div_rsp.ovf, div_rsp.quot);
    assign out_load  = (state_reg == epvt_pkg::ST_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            epvt_pkg::ST_IDLE:     if (sample.valid) state_next = epvt_pkg::ST_OFS;
            epvt_pkg::ST_OFS:      state_next = epvt_pkg::ST_POS;
            epvt_pkg::ST_POS:      state_next = epvt_pkg::ST_CMP;
            epvt_pkg::ST_CMP:
            begin
                if (pos_reg == last_pos_reg) state_next = epvt_pkg::ST_IDLE;
                else                         state_next = epvt_pkg::ST_MOD_GO;
            end
            epvt_pkg::ST_MOD_GO:   state_next = epvt_pkg::ST_MOD_WAIT;
            epvt_pkg::ST_MOD_WAIT: if (div_rsp.done) state_next = epvt_pkg::ST_ANG_MUL;
            epvt_pkg::ST_ANG_MUL:  state_next = epvt_pkg::ST_ANG_GO;
            epvt_pkg::ST_ANG_GO:   state_next = epvt_pkg::ST_ANG_WAIT;
            epvt_pkg::ST_ANG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (dt_reg == 32'd0) state_next = epvt_pkg::ST_OUT;
                    else                 state_next = epvt_pkg::ST_DEN_MUL;
                end
            end
            epvt_pkg::ST_DEN_MUL:  state_next = epvt_pkg::ST_NUM_MUL;
            epvt_pkg::ST_NUM_MUL:  state_next = epvt_pkg::ST_LO_MUL;
            epvt_pkg::ST_LO_MUL:   state_next = epvt_pkg::ST_HI_MUL;
            epvt_pkg::ST_HI_MUL:   state_next = epvt_pkg::ST_SUM;
            epvt_pkg::ST_SUM:      state_next = epvt_pkg::ST_VEL_GO;
            epvt_pkg::ST_VEL_GO:   state_next = epvt_pkg::ST_VEL_WAIT;
            epvt_pkg::ST_VEL_WAIT: if (div_rsp.done) state_next = epvt_pkg::ST_DV_MUL;
            epvt_pkg::ST_DV_MUL:   state_next = epvt_pkg::ST_ACC_GO;
            epvt_pkg::ST_ACC_GO:   state_next = epvt_pkg::ST_ACC_WAIT;
            epvt_pkg::ST_ACC_WAIT: if (div_rsp.done) state_next = epvt_pkg::ST_OUT;
            epvt_pkg::ST_OUT:      if (out_load) state_next = epvt_pkg::ST_IDLE;
            default:               state_next = epvt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample.ready     = 1'b0;
        mul_req.a        = '0;
        mul_req.b        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.iters    = '0;
        unique case (state_reg)
            epvt_pkg::ST_IDLE:
            begin
                sample.ready = 1'b1;
            end
            epvt_pkg::ST_MOD_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {pmag_reg, 36'd0};
                div_req.divisor  = epvt_pkg::DEN_W'(epr_eff);
                div_req.iters    = epvt_pkg::ITERS_32;
            end
            epvt_pkg::ST_ANG_MUL:
            begin
                mul_req.a = epvt_pkg::MUL_A_W'(modr_reg);
                mul_req.b = epvt_pkg::CDEG_PER_REV;
            end
            epvt_pkg::ST_ANG_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_prod[31:0], 36'd0};
                div_req.divisor  = epvt_pkg::DEN_W'(epr_eff);
                div_req.iters    = epvt_pkg::ITERS_32;
            end
            epvt_pkg::ST_DEN_MUL:
            begin
                mul_req.a = epvt_pkg::MUL_A_W'(dt_reg);
                mul_req.b = epvt_pkg::MUL_B_W'(epr_eff);
            end
            epvt_pkg::ST_NUM_MUL:
            begin
                mul_req.a = epvt_pkg::MUL_A_W'(dmag_reg);
                mul_req.b = epvt_pkg::CDEG_PER_REV;
            end
            epvt_pkg::ST_LO_MUL:
            begin
                mul_req.a = epvt_pkg::MUL_A_W'(mul_prod[24:0]);
                mul_req.b = epvt_pkg::US_PER_S;
            end
            epvt_pkg::ST_HI_MUL:
            begin
                mul_req.a = epvt_pkg::MUL_A_W'(x_reg[47:25]);
                mul_req.b = epvt_pkg::US_PER_S;
            end
            epvt_pkg::ST_VEL_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg;
                div_req.divisor  = den_reg;
                div_req.iters    = epvt_pkg::ITERS_VEL;
            end
            epvt_pkg::ST_DV_MUL:
            begin
                mul_req.a = dv_abs;
                mul_req.b = epvt_pkg::US_PER_S;
            end
            epvt_pkg::ST_ACC_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_prod, 15'd0};
                div_req.divisor  = epvt_pkg::DEN_W'(dt_reg);
                div_req.iters    = epvt_pkg::ITERS_ACC;
            end
            default:
            begin
                sample.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= epvt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            epr_reg       <= epvt_pkg::EPR_RESET;
            offset_reg    <= '0;
            last_pos_reg  <= '0;
            last_time_reg <= '0;
            last_vel_reg  <= '0;
            held_acc_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                epr_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == epvt_pkg::ST_OFS)
            begin
                unique case (ev_reg)
                    epvt_pkg::LIMIT_HIGH: offset_reg <= epvt_pkg::clamp32(ofs_ext + LIM_HI);
                    epvt_pkg::LIMIT_LOW:  offset_reg <= epvt_pkg::clamp32(ofs_ext + LIM_LO);
                    default:              offset_reg <= offset_reg;
                endcase
            end
            if (state_reg == epvt_pkg::ST_CMP && pos_reg != last_pos_reg)
            begin
                last_pos_reg <= pos_reg;
            end
            if (state_reg == epvt_pkg::ST_ACC_WAIT && div_rsp.done)
            begin
                last_vel_reg  <= vel_reg;
                held_acc_reg  <= acc_val;
                last_time_reg <= time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            epvt_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    raw_reg  <= sample.raw_count;
                    ev_reg   <= sample.limit_event;
                    time_reg <= sample.time_us;
                end
            end
            epvt_pkg::ST_POS:
            begin
                pos_reg <= epvt_pkg::clamp32(ofs_ext + raw_ext);
            end
            epvt_pkg::ST_CMP:
            begin
                dneg_reg <= delta[32];
                dmag_reg <= delta_abs[31:0];
                pneg_reg <= pos_reg[31];
                pmag_reg <= pos_abs[31:0];
                dt_reg   <= time_reg - last_time_reg;
            end
            epvt_pkg::ST_MOD_WAIT:
            begin
                if (div_rsp.done) modr_reg <= mod_fix;
            end
            epvt_pkg::ST_ANG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ang_reg <= $signed(ang_val);
                    vel_reg <= last_vel_reg;
                    acc_reg <= held_acc_reg;
                end
            end
            epvt_pkg::ST_NUM_MUL:
            begin
                den_reg <= mul_prod[47:0];
            end
            epvt_pkg::ST_LO_MUL:
            begin
                x_reg <= mul_prod[47:0];
            end
            epvt_pkg::ST_HI_MUL:
            begin
                lo_reg <= mul_prod[44:0];
            end
            epvt_pkg::ST_SUM:
            begin
                num_reg <= num_sum;
            end
            epvt_pkg::ST_VEL_WAIT:
            begin
                if (div_rsp.done) vel_reg <= vel_val;
            end
            epvt_pkg::ST_DV_MUL:
            begin
                dvneg_reg <= dv[32];
            end
            epvt_pkg::ST_ACC_WAIT:
            begin
                if (div_rsp.done) acc_reg <= acc_val;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_pos_reg <= pos_reg;
            out_ang_reg <= ang_reg;
            out_vel_reg <= vel_reg;
            out_acc_reg <= acc_reg;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.position            = out_pos_reg;
    assign result.angle_centideg      = out_ang_reg;
    assign result.velocity_centideg_s = out_vel_reg;
    assign result.accel_centideg_s2   = out_acc_reg;

    // The shared divider is only started when it has finished its previous pass.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A divider completion always follows a pass that was running.
    a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider done without a running pass");

    // Every delivered angle lies in the half-open range of one revolution.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.angle_centideg >= -16'sd18000) &&
                         (result.angle_centideg < 16'sd18000))
        else $error("angle out of range");

    // The timestamp state moves only at the end of a full rate update.
    a_time_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != epvt_pkg::ST_ACC_WAIT) |=> $stable(last_time_reg))
        else $error("last time changed outside a rate update");

endmodule

`default_nettype wire

// ----- rtl/epvt_mul.sv -----
// Shared multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module epvt_mul (
    input  wire  logic                          clk,
    input  wire  epvt_pkg::mul_req_t            req,
    output logic [epvt_pkg::PROD_W-1:0]         prod
);

    logic [epvt_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{epvt_pkg::MUL_B_W{1'b0}}, req.a} * {{epvt_pkg::MUL_A_W{1'b0}}, req.b};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/epvt_div.sv -----
// Shared radix-2 restoring divider with a quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module epvt_div (
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  epvt_pkg::div_req_t req,
    output epvt_pkg::div_rsp_t       rsp
);

    localparam int DIV_W  = epvt_pkg::DIV_W;
    localparam int DEN_W  = epvt_pkg::DEN_W;
    localparam int QUO_W  = epvt_pkg::QUO_W;
    localparam int ITER_W = epvt_pkg::ITER_W;

    logic [DIV_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quot_reg;
    logic              ovf_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              done_reg;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg, num_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == ITER_W'(1));
            if (req.start)
            begin
                cnt_reg <= req.iters;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.dividend;
            den_reg  <= req.divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg  <= {num_reg[DIV_W-2:0], 1'b0};
            rem_reg  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quot_reg <= {quot_reg[QUO_W-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[QUO_W-1];
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire
